[hw/rtl/dq_pkg.sv]
// dq_pkg: shared types, codes and defaults for the double-ended queue core
// no dependencies
`timescale 1ns / 1ps

package dq_pkg;

  localparam int unsigned DEPTH_DEFAULT      = 256;
  localparam int unsigned DATA_WIDTH_DEFAULT = 32;

  localparam int unsigned REQ_W    = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned OCC_W    = 9;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_PEEK_FRONT = 3'd4,
    REQ_PEEK_BACK  = 3'd5,
    REQ_SIZE       = 3'd6,
    REQ_CLEAR      = 3'd7
  } req_type_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage

[hw/rtl/dq_if.sv]
// dq_req_if / dq_rsp_if: valid-ready channels for requests and results
// depends on dq_pkg
`timescale 1ns / 1ps

interface dq_req_if;
  logic                                valid;
  logic                                ready;
  logic [dq_pkg::REQ_W-1:0]            req_type;
  logic signed [dq_pkg::VALUE_W-1:0]   element_value;

  modport source (output valid, output req_type, output element_value, input ready);
  modport sink   (input valid, input req_type, input element_value, output ready);
endinterface

interface dq_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [dq_pkg::STATUS_W-1:0]         status;
  logic signed [dq_pkg::VALUE_W-1:0]   read_value;
  logic [dq_pkg::OCC_W-1:0]            occupancy;

  modport source (output valid, output status, output read_value, output occupancy,
                  input ready);
  modport sink   (input valid, input status, input read_value, input occupancy,
                  output ready);
endinterface

[hw/rtl/dq_ram.sv]
// dq_ram: generic single-port synchronous ram with registered read
// no dependencies
`timescale 1ns / 1ps

module dq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wr_data,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[addr];
    end
  end

endmodule

[hw/rtl/double_ended_queue_core.sv]
// double_ended_queue_core: bounded deque of words in a ring held in one ram
// depends on dq_pkg, dq_req_if / dq_rsp_if and dq_ram
// Requests arrive on req and each one gives exactly one result on rsp, in order.
// One request is accepted per cycle; its result is registered in the ram read and
// s1 stage and then in the output register, and a stall on rsp holds back req
// only once the stage between them is occupied. Head index and count live in
// flip-flops and are updated at the transfer; each request makes at most one
// access to the single ram port, so back-to-back requests on the same
// slot need no forwarding. A push on a full deque returns full status and a pop or
// peek on an empty one returns empty status, both with read_value zero.
`timescale 1ns / 1ps

module double_ended_queue_core #(
  parameter int unsigned DEPTH      = dq_pkg::DEPTH_DEFAULT,
  parameter int unsigned DATA_WIDTH = dq_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic     clk,
  input  logic     rst,
  dq_req_if.sink   req,
  dq_rsp_if.source rsp
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  logic [IW-1:0] head;
  logic [CW-1:0] count;
  logic [IW-1:0] head_next;
  logic [CW-1:0] count_next;

  logic                  s1_valid;
  dq_pkg::status_t       s1_status;
  logic                  s1_rd;
  logic [dq_pkg::OCC_W-1:0] s1_occ;

  logic accept;
  logic out_load;

  dq_pkg::req_type_t kind;
  dq_pkg::status_t   st;
  logic              rd_flag;
  logic              mem_we;
  logic              mem_re;
  logic [IW-1:0]     mem_addr;
  logic [DATA_WIDTH-1:0] rdata;

  logic          is_full;
  logic          is_empty;
  logic [SW-1:0] sum_tail;
  logic [SW-1:0] sum_back;
  logic [IW-1:0] tail_slot;
  logic [IW-1:0] back_slot;
  logic [IW-1:0] head_prev;
  logic [IW-1:0] head_inc;

  assign out_load  = s1_valid && (!rsp.valid || rsp.ready);
  assign req.ready = !rst && (!s1_valid || out_load);
  assign accept    = req.valid && req.ready;

  assign kind     = dq_pkg::req_type_t'(req.req_type);
  assign is_full  = (count == CW'(DEPTH));
  assign is_empty = (count == '0);

  assign sum_tail  = SW'(head) + SW'(count);
  assign sum_back  = sum_tail - SW'(1);
  assign tail_slot = (sum_tail >= SW'(DEPTH)) ? IW'(sum_tail - SW'(DEPTH)) : IW'(sum_tail);
  assign back_slot = (sum_back >= SW'(DEPTH)) ? IW'(sum_back - SW'(DEPTH)) : IW'(sum_back);
  assign head_prev = (head == '0) ? IW'(DEPTH - 1) : head - IW'(1);
  assign head_inc  = (head == IW'(DEPTH - 1)) ? '0 : head + IW'(1);

  always_comb begin
    head_next  = head;
    count_next = count;
    st         = dq_pkg::ST_OK;
    rd_flag    = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_addr   = head;
    case (kind)
      dq_pkg::REQ_PUSH_FRONT, dq_pkg::REQ_PUSH_BACK: begin
        if (is_full) begin
          st = dq_pkg::ST_FULL;
        end else begin
          mem_we     = 1'b1;
          count_next = count + CW'(1);
          if (kind == dq_pkg::REQ_PUSH_FRONT) begin
            head_next = head_prev;
            mem_addr  = head_prev;
          end else begin
            mem_addr = tail_slot;
          end
        end
      end
      dq_pkg::REQ_POP_FRONT, dq_pkg::REQ_POP_BACK,
      dq_pkg::REQ_PEEK_FRONT, dq_pkg::REQ_PEEK_BACK: begin
        if (is_empty) begin
          st = dq_pkg::ST_EMPTY;
        end else begin
          mem_re  = 1'b1;
          rd_flag = 1'b1;
          if (kind == dq_pkg::REQ_POP_BACK || kind == dq_pkg::REQ_PEEK_BACK) begin
            mem_addr = back_slot;
          end
          if (kind == dq_pkg::REQ_POP_FRONT) begin
            head_next  = head_inc;
            count_next = count - CW'(1);
          end else if (kind == dq_pkg::REQ_POP_BACK) begin
            count_next = count - CW'(1);
          end
          if (count_next == '0) begin
            head_next = '0;
          end
        end
      end
      dq_pkg::REQ_CLEAR: begin
        head_next  = '0;
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  dq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk     (clk),
    .wr_en   (accept && mem_we),
    .rd_en   (accept && mem_re),
    .addr    (mem_addr),
    .wr_data (DATA_WIDTH'($unsigned(req.element_value))),
    .rd_data (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      count     <= '0;
      s1_valid  <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (accept) begin
        head     <= head_next;
        count    <= count_next;
        s1_valid <= 1'b1;
      end else if (out_load) begin
        s1_valid <= 1'b0;
      end
      if (out_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status <= st;
      s1_rd     <= rd_flag;
      s1_occ    <= dq_pkg::OCC_W'(count_next);
    end
    if (out_load) begin
      rsp.status     <= s1_status;
      rsp.read_value <= s1_rd ? dq_pkg::VALUE_W'($signed(rdata)) : '0;
      rsp.occupancy  <= s1_occ;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("count above depth");

  a_empty_head: assert property (@(posedge clk) disable iff (rst)
    count == '0 |-> head == '0)
    else $error("head not reset on empty deque");

  a_status_value: assert property (@(posedge clk) disable iff (rst)
    out_load && (s1_status == dq_pkg::ST_EMPTY || s1_status == dq_pkg::ST_FULL)
    |=> rsp.read_value == '0)
    else $error("nonzero word on error result");

  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
    accept && st == dq_pkg::ST_EMPTY |=> s1_occ == '0)
    else $error("empty status with nonzero occupancy");

endmodule

[sim/double_ended_queue_core_tb.sv]
// double_ended_queue_core_tb: self-checking bench for the deque core, with a directed
// opening and random request streams under varied valid/ready idling
// depends on dq_pkg, dq_req_if / dq_rsp_if and double_ended_queue_core
`timescale 1ns / 1ps

module double_ended_queue_core_tb;

  localparam int unsigned DEPTH       = dq_pkg::DEPTH_DEFAULT;
  localparam int unsigned IDX_W       = $clog2(dq_pkg::DEPTH_DEFAULT);
  localparam int          QUIET_LIMIT = 1000;
  localparam int          PHASE_ITEMS = 170;

  typedef struct {
    dq_pkg::status_t                   status;
    logic signed [dq_pkg::VALUE_W-1:0] read_value;
    logic [dq_pkg::OCC_W-1:0]          occupancy;
  } deque_result_t;

  class deque_scoreboard;
    logic signed [dq_pkg::VALUE_W-1:0] slots [DEPTH];
    logic [IDX_W-1:0]                  head;
    logic [dq_pkg::OCC_W-1:0]          count;
    deque_result_t                     expected_q [$];
    int                                errors;

    function new();
      head   = '0;
      count  = '0;
      errors = 0;
    endfunction

    function void note_request(dq_pkg::req_type_t kind,
                               logic signed [dq_pkg::VALUE_W-1:0] word);
      deque_result_t    r;
      logic [IDX_W-1:0] slot;
      r.status     = dq_pkg::ST_OK;
      r.read_value = '0;
      case (kind)
        dq_pkg::REQ_PUSH_FRONT, dq_pkg::REQ_PUSH_BACK: begin
          if (count == DEPTH) begin
            r.status = dq_pkg::ST_FULL;
          end else begin
            if (kind == dq_pkg::REQ_PUSH_FRONT) begin
              head = head - 1'b1;
              slot = head;
            end else begin
              slot = head + count[IDX_W-1:0];
            end
            slots[slot] = word;
            count       = count + 1'b1;
          end
        end
        dq_pkg::REQ_POP_FRONT, dq_pkg::REQ_POP_BACK,
        dq_pkg::REQ_PEEK_FRONT, dq_pkg::REQ_PEEK_BACK: begin
          if (count == 0) begin
            r.status = dq_pkg::ST_EMPTY;
          end else begin
            if (kind == dq_pkg::REQ_POP_FRONT || kind == dq_pkg::REQ_PEEK_FRONT) slot = head;
            else slot = head + count[IDX_W-1:0] - 1'b1;
            r.read_value = slots[slot];
            if (kind == dq_pkg::REQ_POP_FRONT) begin
              head  = head + 1'b1;
              count = count - 1'b1;
            end else if (kind == dq_pkg::REQ_POP_BACK) begin
              count = count - 1'b1;
            end
            if (count == 0) head = '0;
          end
        end
        dq_pkg::REQ_SIZE: ;
        default: begin
          head  = '0;
          count = '0;
        end
      endcase
      r.occupancy = count;
      expected_q.insert(expected_q.size(), r);
    endfunction

    function void check_result(logic [dq_pkg::STATUS_W-1:0] st,
                               logic signed [dq_pkg::VALUE_W-1:0] rd,
                               logic [dq_pkg::OCC_W-1:0] occ);
      deque_result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result status=%0d read_value=%h occupancy=%0d",
                 $time, st, rd, occ);
        errors++;
      end else begin
        e = expected_q[0];
        expected_q.delete(0);
        if (st !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, st);
          errors++;
        end
        if (rd !== e.read_value) begin
          $display("%0t: read_value expected %h actual %h", $time, e.read_value, rd);
          errors++;
        end
        if (occ !== e.occupancy) begin
          $display("%0t: occupancy expected %0d actual %0d", $time, e.occupancy, occ);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   send_idle_pct = 0;
  int   stall_pct     = 0;
  int   fill_target   = DEPTH;
  bit   timed_out     = 1'b0;

  deque_scoreboard sb = new();

  dq_req_if req_ch ();
  dq_rsp_if rsp_ch ();

  double_ended_queue_core u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    req_ch.valid         = 1'b0;
    req_ch.req_type      = dq_pkg::REQ_SIZE;
    req_ch.element_value = '0;
    rsp_ch.ready         = 1'b0;
  end

  always @(negedge clk) begin
    rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
      sb.check_result(rsp_ch.status, rsp_ch.read_value, rsp_ch.occupancy);
  end

  task automatic send_req(input dq_pkg::req_type_t kind,
                          input logic signed [dq_pkg::VALUE_W-1:0] word);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
    end
    @(negedge clk);
    req_ch.valid         <= 1'b1;
    req_ch.req_type      <= kind;
    req_ch.element_value <= word;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    sb.note_request(kind, word);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [dq_pkg::VALUE_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // steer occupancy toward a moving target so that full and empty both get hit
  task automatic run_random(input int n);
    dq_pkg::req_type_t kind;
    int                r;
    for (int i = 0; i < n; i++) begin
      if (sb.count == fill_target && $urandom_range(0, 3) == 0) begin
        r = $urandom_range(0, 9);
        if (r < 3) fill_target = DEPTH;
        else if (r < 5) fill_target = 0;
        else fill_target = $urandom_range(1, DEPTH - 1);
      end
      if (sb.count != fill_target && $urandom_range(0, 99) < 90) begin
        if (sb.count < fill_target)
          kind = $urandom_range(0, 1) ? dq_pkg::REQ_PUSH_BACK : dq_pkg::REQ_PUSH_FRONT;
        else
          kind = $urandom_range(0, 1) ? dq_pkg::REQ_POP_BACK : dq_pkg::REQ_POP_FRONT;
      end else if (sb.count == DEPTH && $urandom_range(0, 1)) begin
        kind = $urandom_range(0, 1) ? dq_pkg::REQ_PUSH_BACK : dq_pkg::REQ_PUSH_FRONT;
      end else begin
        kind = dq_pkg::req_type_t'($urandom_range(0, 7));
        if (kind == dq_pkg::REQ_CLEAR && $urandom_range(0, 3) != 0)
          kind = dq_pkg::REQ_PEEK_BACK;
      end
      send_req(kind, pick_word());
    end
  endtask

  task automatic run_test();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty deque errors, then a size query
    send_req(dq_pkg::REQ_PEEK_FRONT, 32'h1234_5678);
    send_req(dq_pkg::REQ_POP_BACK,   '0);
    send_req(dq_pkg::REQ_POP_FRONT,  '1);
    send_req(dq_pkg::REQ_PEEK_BACK,  '0);
    send_req(dq_pkg::REQ_SIZE,       '0);
    // extremes at both ends
    send_req(dq_pkg::REQ_PUSH_FRONT, 32'h7fff_ffff);
    send_req(dq_pkg::REQ_PUSH_BACK,  32'h8000_0000);
    send_req(dq_pkg::REQ_PUSH_BACK,  '1);
    send_req(dq_pkg::REQ_PUSH_FRONT, '0);
    send_req(dq_pkg::REQ_PEEK_FRONT, '0);
    send_req(dq_pkg::REQ_PEEK_BACK,  '0);
    send_req(dq_pkg::REQ_SIZE,       32'hdead_beef);
    send_req(dq_pkg::REQ_POP_BACK,   '0);
    send_req(dq_pkg::REQ_POP_FRONT,  '0);
    send_req(dq_pkg::REQ_POP_BACK,   '0);
    // last word leaves through the back
    send_req(dq_pkg::REQ_POP_BACK,   '0);
    send_req(dq_pkg::REQ_PEEK_FRONT, '0);
    send_req(dq_pkg::REQ_PUSH_BACK,  32'h5555_5555);
    send_req(dq_pkg::REQ_PUSH_FRONT, 32'haaaa_aaaa);
    send_req(dq_pkg::REQ_POP_FRONT,  '0);
    send_req(dq_pkg::REQ_CLEAR,      '0);
    send_req(dq_pkg::REQ_SIZE,       '0);
    send_req(dq_pkg::REQ_POP_FRONT,  '0);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 57; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 57; end
        default: begin send_idle_pct = 27; stall_pct = 27; end
      endcase
      run_random(PHASE_ITEMS);
      wait_drained();
    end
    stall_pct = 0;
    repeat (8) @(posedge clk);
  endtask

  task automatic watch_transfers();
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
  endtask

  initial begin
    fork
      run_test();
      begin
        watch_transfers();
        timed_out = 1'b1;
      end
    join_any
    if (timed_out || sb.errors != 0 || sb.expected_q.size() != 0) begin
      $display("FAIL");
    end else begin
      $display("PASS");
    end
    $finish;
  end

endmodule
